[rtl/core/rau_pkg.sv]
`default_nettype none

package rau_pkg;

    // fixed field widths
    localparam int DATA_W          = 32;
    localparam int DEN_W           = 31;
    localparam int OP_W            = 4;
    localparam int STAT_W          = 2;
    localparam int DEF_WORD_WIDTH  = 32;
    localparam int DEF_QUEUE_DEPTH = 2;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_EQ  = 4'd4,
        OP_NE  = 4'd5,
        OP_GE  = 4'd6,
        OP_LE  = 4'd7,
        OP_GT  = 4'd8,
        OP_LT  = 4'd9
    } op_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_ZDEN = 2'd1,
        STAT_DIVZ = 2'd2,
        STAT_OVF  = 2'd3
    } status_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_STORE,
        ST_MUL,
        ST_COMB
    } state_t;

    // which value is being reduced
    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_R
    } phase_t;

    typedef struct packed {
        logic [OP_W-1:0]          req_type;
        logic signed [DATA_W-1:0] num_a;
        logic signed [DATA_W-1:0] den_a;
        logic signed [DATA_W-1:0] num_b;
        logic signed [DATA_W-1:0] den_b;
    } rau_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_num;
        logic [DEN_W-1:0]         res_den;
        logic                     cmp_true;
        logic [STAT_W-1:0]        status;
    } rau_out_t;

    // classified request as queued between front and back
    typedef struct packed {
        rau_in_t req;
        logic    bad_op;
        logic    zero_den;
    } rau_item_t;

endpackage

`default_nettype wire

[rtl/core/rau_front.sv]
`default_nettype none

module rau_front
    import rau_pkg::*;
#(
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
)
(
    input  wire logic      start,
    input  wire rau_in_t   req,
    input  wire logic      q_full,
    output logic           busy,
    output logic           push,
    output rau_item_t      item
);

    logic [WORD_WIDTH-1:0] den_a_w;
    logic [WORD_WIDTH-1:0] den_b_w;

    // accept whenever the queue has room
    assign busy = q_full;
    assign push = start && !q_full;

    // classify the request
    assign den_a_w       = req.den_a[WORD_WIDTH-1:0];
    assign den_b_w       = req.den_b[WORD_WIDTH-1:0];
    assign item.req      = req;
    assign item.bad_op   = (req.req_type > OP_LT);
    assign item.zero_den = (den_a_w == '0) || (den_b_w == '0);

endmodule

`default_nettype wire

[rtl/core/rau_queue.sv]
`default_nettype none

module rau_queue
    import rau_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire rau_item_t wr_item,
    input  wire logic      pop,
    output rau_item_t      rd_item,
    output logic           full,
    output logic           empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rau_item_t       mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
    // no transfer into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("push into full queue");
    // no read from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

[rtl/core/rau_back.sv]
`default_nettype none

module rau_back
    import rau_pkg::*;
#(
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire rau_item_t item,
    input  wire logic      empty,
    output logic           pop,
    output logic           done,
    output rau_out_t       res
);

    localparam int W  = WORD_WIDTH;
    localparam int D  = 2 * W + 1;
    localparam int KW = $clog2(D + 1);
    localparam int CW = $clog2(D + 1);
    localparam logic [D-1:0] LIM = D'(1) << (W - 1);

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] s);
        mag_of = s[W-1] ? (~s + 1'b1) : s;
    endfunction

    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic            an_neg_reg, an_neg_next, bn_neg_reg, bn_neg_next;
    logic            da_neg_reg, da_neg_next, db_neg_reg, db_neg_next;
    logic [W-1:0]    an_reg, an_next, ad_reg, ad_next;
    logic [W-1:0]    bn_reg, bn_next, bd_reg, bd_next;
    logic            sn_neg_reg, sn_neg_next;
    logic [D-1:0]    rx_reg, rx_next, ry_reg, ry_next;
    logic [D-1:0]    u_reg, u_next, v_reg, v_next, g_reg, g_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [D-1:0]    ax_reg, ax_next, ay_reg, ay_next;
    logic [D-1:0]    qx_reg, qx_next, qy_reg, qy_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [1:0]      mcnt_reg, mcnt_next;
    logic [2*W-1:0]  p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    rau_out_t        res_reg, res_next;
    logic            done_reg, done_next;

    // datapath signals
    logic [D-1:0]    u_sub, v_sub, g_shift;
    logic            u_ge_v;
    logic [D:0]      tx, ty, tx_sub, ty_sub;
    logic            tx_ge, ty_ge;
    logic [W-1:0]    mx, my;
    logic [2*W-1:0]  prod;
    logic [D-1:0]    xs, ys, sum_mag;
    logic            t_neg, sum_neg;
    logic            c_lt, c_eq, cmp_bit;
    logic            is_cmp;
    logic            r_neg, ovf;
    logic signed [W-1:0] r_val;
    logic [W-1:0]    na_w, da_w, nb_w, db_w;

    assign pop  = (state_reg == ST_IDLE) && !empty;
    assign done = done_reg;
    assign res  = res_reg;

    // binary gcd step
    assign u_ge_v  = (u_reg >= v_reg);
    assign u_sub   = u_reg - v_reg;
    assign v_sub   = v_reg - u_reg;
    assign g_shift = v_reg << k_reg;

    // two restoring divider lanes sharing one divisor
    assign tx     = {ax_reg, qx_reg[D-1]};
    assign ty     = {ay_reg, qy_reg[D-1]};
    assign tx_ge  = (tx >= {1'b0, g_reg});
    assign ty_ge  = (ty >= {1'b0, g_reg});
    assign tx_sub = tx - {1'b0, g_reg};
    assign ty_sub = ty - {1'b0, g_reg};

    // shared multiplier operand select
    always_comb
    begin
        case (mcnt_reg)
            2'd0:
            begin
                mx = an_reg;
                my = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            2'd1:
            begin
                mx = bn_reg;
                my = ad_reg;
            end
            default:
            begin
                mx = ad_reg;
                my = (op_reg == OP_DIV) ? bn_reg : bd_reg;
            end
        endcase
    end
    assign prod = (2 * W)'(mx) * (2 * W)'(my);

    // signed sum of the cross products
    always_comb
    begin
        xs    = D'(p0_reg);
        ys    = D'(p1_reg);
        t_neg = (p1_reg != '0) && (bn_neg_reg ^ (op_reg == OP_SUB));
        if (an_neg_reg == t_neg)
        begin
            sum_mag = xs + ys;
            sum_neg = an_neg_reg;
        end
        else if (xs >= ys)
        begin
            sum_mag = xs - ys;
            sum_neg = an_neg_reg;
        end
        else
        begin
            sum_mag = ys - xs;
            sum_neg = t_neg;
        end
        if (sum_mag == '0)
        begin
            sum_neg = 1'b0;
        end
    end

    // compare of a*bd against b*ad
    always_comb
    begin
        c_eq = 1'b0;
        c_lt = 1'b0;
        if (an_neg_reg != bn_neg_reg)
        begin
            c_lt = an_neg_reg;
        end
        else if (p0_reg == p1_reg)
        begin
            c_eq = 1'b1;
        end
        else if (an_neg_reg)
        begin
            c_lt = (p0_reg > p1_reg);
        end
        else
        begin
            c_lt = (p0_reg < p1_reg);
        end
        case (op_reg)
            OP_EQ:   cmp_bit = c_eq;
            OP_NE:   cmp_bit = !c_eq;
            OP_GE:   cmp_bit = !c_lt;
            OP_LE:   cmp_bit = c_lt || c_eq;
            OP_GT:   cmp_bit = !c_lt && !c_eq;
            default: cmp_bit = c_lt;
        endcase
    end
    assign is_cmp = (op_reg >= OP_EQ);

    // final result range check and formatting
    assign r_neg = (qx_reg != '0) && sn_neg_reg;
    assign ovf   = (qy_reg > LIM - 1'b1) ||
                   (r_neg ? (qx_reg > LIM) : (qx_reg > LIM - 1'b1));
    assign r_val = r_neg ? -$signed(qx_reg[W-1:0]) : $signed(qx_reg[W-1:0]);

    // operand words
    assign na_w = item.req.num_a[W-1:0];
    assign da_w = item.req.den_a[W-1:0];
    assign nb_w = item.req.num_b[W-1:0];
    assign db_w = item.req.den_b[W-1:0];

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        op_next     = op_reg;
        an_neg_next = an_neg_reg;
        bn_neg_next = bn_neg_reg;
        da_neg_next = da_neg_reg;
        db_neg_next = db_neg_reg;
        an_next     = an_reg;
        ad_next     = ad_reg;
        bn_next     = bn_reg;
        bd_next     = bd_reg;
        sn_neg_next = sn_neg_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        g_next      = g_reg;
        k_next      = k_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        qx_next     = qx_reg;
        qy_next     = qy_reg;
        cnt_next    = cnt_reg;
        mcnt_next   = mcnt_reg;
        p0_next     = p0_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        res_next    = res_reg;
        done_next   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    op_next           = item.req.req_type;
                    res_next.res_num  = '0;
                    res_next.res_den  = DEN_W'(1);
                    res_next.cmp_true = 1'b0;
                    res_next.status   = STAT_OK;
                    if (item.bad_op)
                    begin
                        done_next = 1'b1;
                    end
                    else if (item.zero_den)
                    begin
                        res_next.status = STAT_ZDEN;
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        an_neg_next = na_w[W-1];
                        da_neg_next = da_w[W-1];
                        bn_neg_next = nb_w[W-1];
                        db_neg_next = db_w[W-1];
                        an_next     = mag_of(na_w);
                        ad_next     = mag_of(da_w);
                        bn_next     = mag_of(nb_w);
                        bd_next     = mag_of(db_w);
                        rx_next     = D'(mag_of(na_w));
                        ry_next     = D'(mag_of(da_w));
                        u_next      = D'(mag_of(na_w));
                        v_next      = D'(mag_of(da_w));
                        k_next      = '0;
                        phase_next  = PH_A;
                        state_next  = ST_GCD;
                    end
                end
            end

            ST_GCD:
            begin
                if (u_reg == '0)
                begin
                    g_next     = g_shift;
                    ax_next    = '0;
                    ay_next    = '0;
                    qx_next    = rx_reg;
                    qy_next    = ry_reg;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (u_ge_v)
                begin
                    u_next = u_sub;
                end
                else
                begin
                    v_next = v_sub;
                end
            end

            ST_DIV:
            begin
                ax_next  = tx_ge ? tx_sub[D-1:0] : tx[D-1:0];
                ay_next  = ty_ge ? ty_sub[D-1:0] : ty[D-1:0];
                qx_next  = {qx_reg[D-2:0], tx_ge};
                qy_next  = {qy_reg[D-2:0], ty_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(D - 1))
                begin
                    state_next = ST_STORE;
                end
            end

            ST_STORE:
            begin
                case (phase_reg)
                    PH_A:
                    begin
                        an_next     = qx_reg[W-1:0];
                        ad_next     = qy_reg[W-1:0];
                        an_neg_next = (qx_reg != '0) && (an_neg_reg ^ da_neg_reg);
                        rx_next     = D'(bn_reg);
                        ry_next     = D'(bd_reg);
                        u_next      = D'(bn_reg);
                        v_next      = D'(bd_reg);
                        k_next      = '0;
                        phase_next  = PH_B;
                        state_next  = ST_GCD;
                    end
                    PH_B:
                    begin
                        bn_next     = qx_reg[W-1:0];
                        bd_next     = qy_reg[W-1:0];
                        bn_neg_next = (qx_reg != '0) && (bn_neg_reg ^ db_neg_reg);
                        if ((op_reg == OP_DIV) && (qx_reg == '0))
                        begin
                            res_next.status = STAT_DIVZ;
                            done_next       = 1'b1;
                            state_next      = ST_IDLE;
                        end
                        else
                        begin
                            mcnt_next  = '0;
                            state_next = ST_MUL;
                        end
                    end
                    default:
                    begin
                        if (ovf)
                        begin
                            res_next.status = STAT_OVF;
                        end
                        else
                        begin
                            res_next.res_num = DATA_W'(r_val);
                            res_next.res_den = DEN_W'(qy_reg);
                        end
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_MUL:
            begin
                case (mcnt_reg)
                    2'd0:    p0_next = prod;
                    2'd1:    p1_next = prod;
                    default: p2_next = prod;
                endcase
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 2'd2)
                begin
                    state_next = ST_COMB;
                end
            end

            ST_COMB:
            begin
                if (is_cmp)
                begin
                    res_next.cmp_true = cmp_bit;
                    done_next         = 1'b1;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    if ((op_reg == OP_ADD) || (op_reg == OP_SUB))
                    begin
                        rx_next     = sum_mag;
                        u_next      = sum_mag;
                        sn_neg_next = sum_neg;
                    end
                    else
                    begin
                        rx_next     = D'(p0_reg);
                        u_next      = D'(p0_reg);
                        sn_neg_next = an_neg_reg ^ bn_neg_reg;
                    end
                    ry_next    = D'(p2_reg);
                    v_next     = D'(p2_reg);
                    k_next     = '0;
                    phase_next = PH_R;
                    state_next = ST_GCD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_A;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        an_neg_reg <= an_neg_next;
        bn_neg_reg <= bn_neg_next;
        da_neg_reg <= da_neg_next;
        db_neg_reg <= db_neg_next;
        an_reg     <= an_next;
        ad_reg     <= ad_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        sn_neg_reg <= sn_neg_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        g_reg      <= g_next;
        k_reg      <= k_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        cnt_reg    <= cnt_next;
        mcnt_reg   <= mcnt_next;
        p0_reg     <= p0_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        res_reg    <= res_next;
    end

    // gcd never runs with a zero second operand
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == ST_GCD) |-> (v_reg != '0))
        else $error("gcd operand v is zero");
    // every result leaves the sequencer back in idle
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe outside idle");
    // error results carry the fraction 0/1
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (res_reg.status != STAT_OK)) |->
        ((res_reg.res_num == '0) && (res_reg.res_den == DEN_W'(1)) && !res_reg.cmp_true))
        else $error("error result not 0/1");
    // a reduced denominator is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (res_reg.res_den != '0))
        else $error("zero denominator delivered");

endmodule

`default_nettype wire

[rtl/core/rational_arithmetic_unit.sv]
`default_nettype none

// channel   signals            transfer
// -------   ----------------   ---------------------------------------
// request   start, busy, req   rising edge with start high, busy low
// result    done, res          rising edge ending the cycle done is high
//
// one request at a time in the back end: gcd reductions of a and b, each
// followed by a division, then three multiplier products; arithmetic then
// reduces and divides the result, a compare ends after the products, a divide
// by zero ends after reducing b, and an unused code or zero denominator ends
// in idle without any reduction.
// reset clears the queue and the sequencer; no clearing pass is needed.
// the front takes a new request while the back works, until the queue is full.
// results cannot be held off and appear for exactly one cycle.

module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_WIDTH  = DEF_WORD_WIDTH,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire rau_in_t req,
    output logic         done,
    output rau_out_t     res
);

    logic      q_push, q_pop, q_full, q_empty;
    rau_item_t q_wr_item, q_rd_item;

    // accept and classify
    rau_front #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_front (
        .start  (start),
        .req    (req),
        .q_full (q_full),
        .busy   (busy),
        .push   (q_push),
        .item   (q_wr_item)
    );

    // decoupling queue
    rau_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (q_wr_item),
        .pop     (q_pop),
        .rd_item (q_rd_item),
        .full    (q_full),
        .empty   (q_empty)
    );

    // reduce and compute
    rau_back #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (q_rd_item),
        .empty (q_empty),
        .pop   (q_pop),
        .done  (done),
        .res   (res)
    );

endmodule

`default_nettype wire

[tb/rau_checker.sv]
`timescale 1ns / 100ps

module rau_checker
    import rau_pkg::*;
#(
    parameter int WORD_WIDTH = DEF_WORD_WIDTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     busy,
    input  wire rau_in_t  req,
    input  wire logic     done,
    input  wire rau_out_t res,
    output int            fail_count,
    output int            pending
);

    // signed value as sign and magnitude, magnitudes up to 2*WORD_WIDTH bits
    typedef struct packed {
        logic         neg;
        logic [127:0] mag;
    } smag_t;

    rau_out_t expected_q[$];

    assign pending = expected_q.size();

    function automatic smag_t word_value(logic [DATA_W-1:0] raw);
        smag_t        r;
        logic [127:0] full;
        logic [127:0] v;
        full  = 128'd1 << WORD_WIDTH;
        v     = {96'd0, raw} & (full - 1);
        r.neg = v[WORD_WIDTH-1];
        r.mag = r.neg ? (full - v) : v;
        return r;
    endfunction

    function automatic logic [127:0] gcd_of(logic [127:0] x, logic [127:0] y);
        logic [127:0] t;
        while (y != 0)
        begin
            t = y;
            y = x % y;
            x = t;
        end
        return x;
    endfunction

    function automatic smag_t times(smag_t x, smag_t y);
        smag_t r;
        r.mag = x.mag * y.mag;
        r.neg = (r.mag != 0) && (x.neg != y.neg);
        return r;
    endfunction

    function automatic smag_t plus(smag_t x, smag_t y);
        smag_t r;
        if (x.neg == y.neg)
        begin
            r.mag = x.mag + y.mag;
            r.neg = x.neg;
        end
        else if (x.mag >= y.mag)
        begin
            r.mag = x.mag - y.mag;
            r.neg = x.neg;
        end
        else
        begin
            r.mag = y.mag - x.mag;
            r.neg = y.neg;
        end
        if (r.mag == 0)
            r.neg = 1'b0;
        return r;
    endfunction

    // -1, 0, 1 ordering of two signed values
    function automatic int order_of(smag_t x, smag_t y);
        if (x.neg != y.neg)
            return x.neg ? -1 : 1;
        if (x.mag == y.mag)
            return 0;
        if (x.neg)
            return (x.mag > y.mag) ? -1 : 1;
        return (x.mag > y.mag) ? 1 : -1;
    endfunction

    // reduce n/d to lowest terms, positive denominator magnitude in d
    function automatic void lowest_terms(input smag_t n, input smag_t d,
                                         output smag_t rn, output smag_t rd);
        logic [127:0] g;
        g      = gcd_of(n.mag, d.mag);
        rn.mag = n.mag / g;
        rn.neg = (rn.mag != 0) && (n.neg != d.neg);
        rd.mag = d.mag / g;
        rd.neg = 1'b0;
    endfunction

    function automatic rau_out_t fraction_result(rau_in_t r);
        rau_out_t     o;
        smag_t        na, da, nb, db, an, ad, bn, bd, sn, sd, rn, rd, t;
        logic [127:0] lim;
        int           c;
        na = word_value(r.num_a);
        da = word_value(r.den_a);
        nb = word_value(r.num_b);
        db = word_value(r.den_b);
        lim = 128'd1 << (WORD_WIDTH - 1);
        o.res_num  = '0;
        o.res_den  = DEN_W'(1);
        o.cmp_true = 1'b0;
        o.status   = STAT_OK;
        if (r.req_type > OP_LT)
            return o;
        if (da.mag == 0 || db.mag == 0)
        begin
            o.status = STAT_ZDEN;
            return o;
        end
        lowest_terms(na, da, an, ad);
        lowest_terms(nb, db, bn, bd);
        if (r.req_type >= OP_EQ)
        begin
            c = order_of(times(an, bd), times(bn, ad));
            case (op_t'(r.req_type))
                OP_EQ: o.cmp_true = (c == 0);
                OP_NE: o.cmp_true = (c != 0);
                OP_GE: o.cmp_true = (c >= 0);
                OP_LE: o.cmp_true = (c <= 0);
                OP_GT: o.cmp_true = (c > 0);
                default: o.cmp_true = (c < 0);
            endcase
            return o;
        end
        if (r.req_type == OP_ADD || r.req_type == OP_SUB)
        begin
            t = times(bn, ad);
            if (r.req_type == OP_SUB && t.mag != 0)
                t.neg = !t.neg;
            sn = plus(times(an, bd), t);
            sd = times(ad, bd);
        end
        else if (r.req_type == OP_MUL)
        begin
            sn = times(an, bn);
            sd = times(ad, bd);
        end
        else
        begin
            if (bn.mag == 0)
            begin
                o.status = STAT_DIVZ;
                return o;
            end
            sn = times(an, bd);
            sd = times(ad, bn);
        end
        lowest_terms(sn, sd, rn, rd);
        if (rd.mag > lim - 1 || (rn.neg ? rn.mag > lim : rn.mag > lim - 1))
        begin
            o.status = STAT_OVF;
            return o;
        end
        o.res_num = rn.neg ? (DATA_W'(0) - rn.mag[DATA_W-1:0]) : rn.mag[DATA_W-1:0];
        o.res_den = rd.mag[DEN_W-1:0];
        return o;
    endfunction

    // predict on each request transfer, compare on each result
    always @(posedge clk or negedge rst_n)
    begin
        rau_out_t exp_res;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (start && !busy)
                expected_q.push_back(fraction_result(req));
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %p", $time, res);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_res = expected_q.pop_front();
                    if (res !== exp_res)
                    begin
                        $display("%0t: expected %p actual %p", $time, exp_res, res);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import rau_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int STALL_LIMIT  = 20000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    rau_in_t  req = '0;
    logic     done;
    rau_out_t res;
    int       fail_count;
    int       pending;
    int       idle_pct = 36;
    int       quiet_cycles = 0;

    always #6 clk = ~clk;

    rational_arithmetic_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .res   (res)
    );

    rau_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n || (pending == 0 && !start))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("rational_arithmetic_unit: mismatch");
            $finish;
        end
    end

    // one request transfer, with random idle cycles ahead of it
    task automatic send_fraction(logic [3:0] op, logic [31:0] na, logic [31:0] da,
                                 logic [31:0] nb, logic [31:0] db);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        req.req_type <= op;
        req.num_a    <= na;
        req.den_a    <= da;
        req.num_b    <= nb;
        req.den_b    <= db;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // random word: mostly small magnitudes, some extremes and full range
    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0, 1:    return $urandom();
            2:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            3:       return -$urandom_range(1, 3);
            4:       return $urandom_range(65535) << $urandom_range(15);
            default: return $urandom_range(1) ? $urandom_range(40) : -$urandom_range(40);
        endcase
    endfunction

    function automatic logic [31:0] pick_den();
        if ($urandom_range(49) == 0)
            return 32'd0;
        return pick_word();
    endfunction

    initial
    begin
        logic [3:0] op;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every operation, extremes, zero denominator, divide by zero
        for (int k = 0; k <= OP_LT; k++)
            send_fraction(4'(k), 32'd3, -32'd6, 32'd5, 32'd10);
        send_fraction(OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        send_fraction(OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        send_fraction(OP_MUL, 32'h8000_0000, 32'hffff_ffff, 32'd1, 32'd1);
        send_fraction(OP_DIV, 32'd7, 32'd3, 32'd0, 32'd5);
        send_fraction(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff);
        send_fraction(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
        send_fraction(OP_LT, 32'd1, 32'd1, 32'd1, 32'd0);
        send_fraction(OP_SUB, 32'd4, 32'd8, 32'd1, 32'd2);
        send_fraction(OP_GE, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'h8000_0000);
        send_fraction(4'd10, 32'd1, 32'd2, 32'd3, 32'd4);
        send_fraction(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_fraction(OP_MUL, 32'h0001_0000, 32'd1, 32'h0000_8000, 32'd1);

        // random phases: sender idles sometimes, often, then never
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_pct = (n < RANDOM_ITEMS / 3) ? 36 : (n < 2 * RANDOM_ITEMS / 3) ? 79 : 0;
            if (n % 97 < 5)
                idle_pct = 0;
            op = ($urandom_range(29) == 0) ? 4'($urandom_range(10, 15))
                                             : 4'($urandom_range(OP_LT));
            send_fraction(op, pick_word(), pick_den(), pick_word(), pick_den());
        end
        start <= 1'b0;

        // drain
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("rational_arithmetic_unit: match");
        else
            $display("rational_arithmetic_unit: mismatch");
        $finish;
    end

endmodule
